[design/ffua_pkg.sv]
`default_nettype none
package ffua_pkg;

  // Fixed field widths of the request and response items.
  localparam int ID_W   = 8;
  localparam int SIZE_W = 11;
  localparam int POS_W  = 10;
  localparam int TAG_W  = ID_W + 1;

  // Response status codes.
  typedef enum logic [1:0] {
    ST_ALLOCATED = 2'd0,
    ST_FAILED    = 2'd1,
    ST_RELEASED  = 2'd2
  } status_t;

  // Request kinds.
  localparam logic KIND_ALLOC   = 1'b0;
  localparam logic KIND_RELEASE = 1'b1;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_ASCAN,
    S_GRANT,
    S_RSCAN,
    S_DONE
  } state_t;

  typedef struct packed {
    logic              kind;
    logic [ID_W-1:0]   process_id;
    logic [SIZE_W-1:0] size;
  } req_t;

  typedef struct packed {
    status_t          status;
    logic [POS_W-1:0] block_start;
    logic [POS_W-1:0] block_end;
  } res_t;

endpackage
`default_nettype wire

[design/ffua_if.sv]
`default_nettype none
// Request channel: one allocate or release item.
interface ffua_req_if
  import ffua_pkg::*;
();
  logic              valid;
  logic              ready;
  logic              kind;
  logic [ID_W-1:0]   process_id;
  logic [SIZE_W-1:0] size;

  modport source (output valid, kind, process_id, size, input ready);
  modport sink   (input valid, kind, process_id, size, output ready);
endinterface

// Response channel: one result item per request.
interface ffua_rsp_if
  import ffua_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [1:0]       status;
  logic [POS_W-1:0] block_start;
  logic [POS_W-1:0] block_end;

  modport source (output valid, status, block_start, block_end, input ready);
  modport sink   (input valid, status, block_start, block_end, output ready);
endinterface
`default_nettype wire

[design/ffua_table.sv]
`default_nettype none
module ffua_table
  import ffua_pkg::*;
#(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [TAG_W-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [TAG_W-1:0] rdata
);

  // Owner tags: bit 8 marks the unit as used, bits 7..0 hold the owner.
  logic [TAG_W-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

[design/ffua_seq.sv]
`default_nettype none
module ffua_seq
  import ffua_pkg::*;
#(
  parameter int UNITS = 1024,
  parameter int AW    = 10
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire req_t             in_req,
  output logic                  res_valid,
  input  wire logic             res_ready,
  output res_t                  res_out,
  output logic                  mem_we,
  output logic      [AW-1:0]    mem_waddr,
  output logic      [TAG_W-1:0] mem_wdata,
  output logic                  mem_re,
  output logic      [AW-1:0]    mem_raddr,
  input  wire logic [TAG_W-1:0] mem_q
);

  localparam int CW = AW + 1;

  state_t          state, state_next;
  logic [CW-1:0]   rd_addr, rd_addr_next;
  logic            p_vld, p_vld_next;
  logic [AW-1:0]   p_addr, p_addr_next;
  logic [CW-1:0]   run_len, run_len_next;
  logic [AW-1:0]   run_first, run_first_next;
  logic [CW-1:0]   req_size, req_size_next;
  logic [ID_W-1:0] req_id, req_id_next;
  logic [AW-1:0]   g_addr, g_addr_next;
  logic [CW-1:0]   g_left, g_left_next;
  res_t            res, res_next;

  logic            rd_done;
  logic [31:0]     size_w;
  logic            size_ok;
  logic [CW-1:0]   len_inc;
  logic [AW-1:0]   start_pos;

  // Unit index to the 10-bit position field, masked as needed.
  function automatic logic [POS_W-1:0] to_pos(input logic [AW-1:0] a);
    logic [31:0] w;
    w = 32'(a);
    return w[POS_W-1:0];
  endfunction

  assign rd_done  = (rd_addr == CW'(UNITS));
  assign size_w   = 32'(in_req.size);
  assign size_ok  = (size_w != 32'd0) && (size_w <= 32'(UNITS));
  assign len_inc  = run_len + CW'(1);
  assign start_pos = (run_len == '0) ? p_addr : run_first;

  assign in_ready = (state == S_IDLE);
  assign res_out  = res;

  // Next state, table accesses and result.
  always_comb begin
    state_next     = state;
    rd_addr_next   = rd_addr;
    p_vld_next     = p_vld;
    p_addr_next    = p_addr;
    run_len_next   = run_len;
    run_first_next = run_first;
    req_size_next  = req_size;
    req_id_next    = req_id;
    g_addr_next    = g_addr;
    g_left_next    = g_left;
    res_next       = res;
    mem_we         = 1'b0;
    mem_waddr      = p_addr;
    mem_wdata      = '0;
    mem_re         = 1'b0;
    mem_raddr      = rd_addr[AW-1:0];
    res_valid      = 1'b0;

    case (state)
      S_CLEAR: begin
        // Clearing pass: mark every unit free, one per cycle.
        mem_we       = 1'b1;
        mem_waddr    = rd_addr[AW-1:0];
        rd_addr_next = rd_addr + CW'(1);
        if (rd_addr == CW'(UNITS - 1)) begin
          state_next = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_valid) begin
          req_id_next  = in_req.process_id;
          rd_addr_next = '0;
          p_vld_next   = 1'b0;
          run_len_next = '0;
          if (in_req.kind == KIND_RELEASE) begin
            state_next = S_RSCAN;
          end else if (size_ok) begin
            req_size_next = size_w[CW-1:0];
            state_next    = S_ASCAN;
          end else begin
            res_next   = '{status: ST_FAILED, block_start: '0, block_end: '0};
            state_next = S_DONE;
          end
        end
      end

      S_ASCAN: begin
        // Stream reads; the tag of the previous address arrives this cycle.
        if (!rd_done) begin
          mem_re       = 1'b1;
          rd_addr_next = rd_addr + CW'(1);
        end
        p_vld_next  = !rd_done;
        p_addr_next = rd_addr[AW-1:0];
        if (p_vld) begin
          if (!mem_q[TAG_W-1]) begin
            run_first_next = start_pos;
            run_len_next   = len_inc;
            if (len_inc == req_size) begin
              g_addr_next = start_pos;
              g_left_next = req_size;
              res_next    = '{status: ST_ALLOCATED, block_start: to_pos(start_pos),
                              block_end: to_pos(p_addr)};
              state_next  = S_GRANT;
            end
          end else begin
            run_len_next = '0;
          end
        end else if (rd_done) begin
          res_next   = '{status: ST_FAILED, block_start: '0, block_end: '0};
          state_next = S_DONE;
        end
      end

      S_GRANT: begin
        // Tag the run with the owner, one unit per cycle.
        mem_we      = 1'b1;
        mem_waddr   = g_addr;
        mem_wdata   = {1'b1, req_id};
        g_addr_next = g_addr + AW'(1);
        g_left_next = g_left - CW'(1);
        if (g_left == CW'(1)) begin
          state_next = S_DONE;
        end
      end

      S_RSCAN: begin
        // Read each unit and free it in the next cycle if the owner matches.
        if (!rd_done) begin
          mem_re       = 1'b1;
          rd_addr_next = rd_addr + CW'(1);
        end
        p_vld_next  = !rd_done;
        p_addr_next = rd_addr[AW-1:0];
        if (p_vld) begin
          if (mem_q == {1'b1, req_id}) begin
            mem_we    = 1'b1;
            mem_waddr = p_addr;
          end
        end else if (rd_done) begin
          res_next   = '{status: ST_RELEASED, block_start: '0, block_end: '0};
          state_next = S_DONE;
        end
      end

      S_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      rd_addr <= '0;
      p_vld   <= 1'b0;
      run_len <= '0;
      g_left  <= '0;
    end else begin
      state   <= state_next;
      rd_addr <= rd_addr_next;
      p_vld   <= p_vld_next;
      run_len <= run_len_next;
      g_left  <= g_left_next;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    p_addr    <= p_addr_next;
    run_first <= run_first_next;
    req_size  <= req_size_next;
    req_id    <= req_id_next;
    g_addr    <= g_addr_next;
    res       <= res_next;
  end

  // A write never targets the entry being read in the same cycle.
  a_no_rw_clash: assert property (@(posedge clk) disable iff (rst)
    mem_we && mem_re |-> mem_waddr != mem_raddr)
    else $error("table read and write hit the same unit");

  // A run that reaches the requested size always leaves the scan.
  a_run_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_ASCAN |-> run_len < req_size)
    else $error("free run grew past the requested size");

  // The grant phase always has a unit left to write.
  a_grant_count: assert property (@(posedge clk) disable iff (rst)
    state == S_GRANT |-> g_left != '0)
    else $error("grant count ran out inside the grant phase");

  // An accepted item always starts work.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> state != S_IDLE)
    else $error("accepted item was dropped");

endmodule
`default_nettype wire

[design/first_fit_unit_allocator_top.sv]
`default_nettype none
// Allocation: accept, scan to the first fitting run (to the end of the table when
// no run fits), then tag each unit of the run, then load the output register.
// Release: one pass over the table, one read per unit and a write-back for each owned unit.
// Rejected sizes go straight to the result. One item is in work at a time.
// After reset the table is cleared before the first item.
module first_fit_unit_allocator_top
  import ffua_pkg::*;
#(
  parameter int UNITS = 1024
) (
  input wire logic  clk,
  input wire logic  rst,
  ffua_req_if.sink  req,
  ffua_rsp_if.source rsp
);

  localparam int AW = (UNITS > 1) ? $clog2(UNITS) : 1;

  req_t             in_req;
  logic             res_valid;
  logic             res_ready;
  res_t             res;
  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  logic [TAG_W-1:0] mem_wdata;
  logic             mem_re;
  logic [AW-1:0]    mem_raddr;
  logic [TAG_W-1:0] mem_q;
  logic             out_vld;
  res_t             out_res;

  assign in_req = '{kind: req.kind, process_id: req.process_id, size: req.size};

  ffua_seq #(
    .UNITS(UNITS),
    .AW   (AW)
  ) u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .in_req   (in_req),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res_out  (res),
    .mem_we   (mem_we),
    .mem_waddr(mem_waddr),
    .mem_wdata(mem_wdata),
    .mem_re   (mem_re),
    .mem_raddr(mem_raddr),
    .mem_q    (mem_q)
  );

  ffua_table #(
    .DEPTH(UNITS),
    .AW   (AW)
  ) u_table (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re   (mem_re),
    .raddr(mem_raddr),
    .rdata(mem_q)
  );

  // Output register: frees the sequencer while the result waits.
  assign res_ready = !out_vld || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (res_ready) begin
      out_vld <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_res <= res;
    end
  end

  assign rsp.valid       = out_vld;
  assign rsp.status      = out_res.status;
  assign rsp.block_start = out_res.block_start;
  assign rsp.block_end   = out_res.block_end;

endmodule
`default_nettype wire

[tb/ffua_checker.sv]
`default_nettype none
// Watches both channels of the allocator, keeps its own copy of the unit
// ownership table and checks every result item against the predicted one.
module ffua_checker
  import ffua_pkg::*;
#(
  parameter int UNITS = 1024
) (
  input  wire logic clk,
  input  wire logic rst,
  ffua_req_if       req,
  ffua_rsp_if       rsp,
  output int        mismatch_count,
  output int        outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  // Bit TAG_W-1 marks a unit as taken, the low bits hold the owner id.
  logic [TAG_W-1:0] unit_owner [UNITS];
  res_t             expected_outcomes [$];

  // Apply one request to the ownership table and return the result it causes.
  function automatic res_t predict_outcome(input req_t r);
    res_t        res;
    int unsigned run_first;
    int unsigned run_len;
    bit          found;
    res.status      = ST_FAILED;
    res.block_start = '0;
    res.block_end   = '0;
    run_first       = 0;
    run_len         = 0;
    found           = 1'b0;
    if (r.kind == KIND_RELEASE) begin
      for (int u = 0; u < UNITS; u++) begin
        if (unit_owner[u] == {1'b1, r.process_id}) begin
          unit_owner[u] = '0;
        end
      end
      res.status = ST_RELEASED;
    end else if (r.size != 0 && r.size <= UNITS) begin
      // First fit: the lowest run of free units that is long enough.
      for (int u = 0; u < UNITS && !found; u++) begin
        if (!unit_owner[u][TAG_W-1]) begin
          if (run_len == 0) begin
            run_first = u;
          end
          run_len++;
          if (run_len == r.size) begin
            found = 1'b1;
          end
        end else begin
          run_len = 0;
        end
      end
      if (found) begin
        for (int u = run_first; u < run_first + r.size; u++) begin
          unit_owner[u] = {1'b1, r.process_id};
        end
        res.status      = ST_ALLOCATED;
        res.block_start = POS_W'(run_first);
        res.block_end   = POS_W'(run_first + r.size - 1);
      end
    end
    return res;
  endfunction

  // Predict on each accepted request item, compare on each accepted result item.
  always @(posedge clk) begin : watch
    req_t request;
    res_t want;
    int   errs;
    errs = 0;
    if (rst) begin
      for (int u = 0; u < UNITS; u++) begin
        unit_owner[u] = '0;
      end
      expected_outcomes.delete();
      mismatch_count <= 0;
    end else begin
      if (req.valid && req.ready) begin
        request.kind       = req.kind;
        request.process_id = req.process_id;
        request.size       = req.size;
        expected_outcomes.push_back(predict_outcome(request));
      end
      if (rsp.valid && rsp.ready) begin
        if (expected_outcomes.size() == 0) begin
          $error("result item with no request waiting: status %0d start %0d end %0d",
                 rsp.status, rsp.block_start, rsp.block_end);
          errs++;
        end else begin
          want = expected_outcomes.pop_front();
          if (rsp.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, rsp.status);
            errs++;
          end
          if (rsp.block_start !== want.block_start) begin
            $error("block_start: expected %0d, got %0d", want.block_start,
                   rsp.block_start);
            errs++;
          end
          if (rsp.block_end !== want.block_end) begin
            $error("block_end: expected %0d, got %0d", want.block_end, rsp.block_end);
            errs++;
          end
        end
      end
      if (errs != 0) begin
        mismatch_count <= mismatch_count + errs;
      end
    end
    outstanding <= expected_outcomes.size();
  end

endmodule
`default_nettype wire

[tb/tb.sv]
`default_nettype none
module tb
  import ffua_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int UNITS        = 1024;
  localparam int RANDOM_ITEMS = 268;
  localparam int POOL_IDS     = 12;
  localparam logic [SIZE_W-1:0] SIZE_FIELD_MAX = '1;

  logic clk = 1'b0;
  logic rst = 1'b1;
  bit   gaps_off = 1'b0;
  int   mismatch_count;
  int   outstanding;
  logic [ID_W-1:0] id_pool [POOL_IDS];

  ffua_req_if req_ch ();
  ffua_rsp_if rsp_ch ();

  first_fit_unit_allocator_top #(.UNITS(UNITS)) uut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  ffua_checker #(.UNITS(UNITS)) watcher (
    .clk            (clk),
    .rst            (rst),
    .req            (req_ch),
    .rsp            (rsp_ch),
    .mismatch_count (mismatch_count),
    .outstanding    (outstanding)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Present one request item after a random gap and hold it until accepted.
  // Called just after the clock rises; valid only drops when a gap follows.
  task automatic send_request(input logic kind, input logic [ID_W-1:0] id,
                              input logic [SIZE_W-1:0] units_wanted);
    int gap;
    gap = gaps_off ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid      <= 1'b1;
    req_ch.kind       <= kind;
    req_ch.process_id <= id;
    req_ch.size       <= units_wanted;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
  endtask

  // Request stream: directed corner cases first, then a random mix.
  initial begin
    int pick;
    int sel;
    logic [ID_W-1:0]   id;
    logic [SIZE_W-1:0] sz;
    req_ch.valid      <= 1'b0;
    req_ch.kind       <= KIND_ALLOC;
    req_ch.process_id <= '0;
    req_ch.size       <= '0;
    for (int i = 0; i < POOL_IDS; i++) begin
      id_pool[i] = ID_W'($urandom_range(0, 255));
    end
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Rejected sizes: zero, just above the table, and the largest field value.
    send_request(KIND_ALLOC, 8'h01, '0);
    send_request(KIND_ALLOC, 8'h01, SIZE_W'(UNITS + 1));
    send_request(KIND_ALLOC, 8'h01, SIZE_FIELD_MAX);
    // Small runs, a duplicate id, and a hole too short for the next request.
    send_request(KIND_ALLOC, 8'h00, 11'd1);
    send_request(KIND_ALLOC, 8'hFF, 11'd3);
    send_request(KIND_ALLOC, 8'h00, 11'd2);
    send_request(KIND_RELEASE, 8'h00, '0);
    send_request(KIND_ALLOC, 8'h07, 11'd2);
    // Releases of an id that owns nothing, and with the size field all ones.
    send_request(KIND_RELEASE, 8'hC8, 11'd5);
    send_request(KIND_RELEASE, 8'hFF, SIZE_FIELD_MAX);
    send_request(KIND_RELEASE, 8'h07, '0);
    // The whole table in one run, then no room left at all.
    send_request(KIND_ALLOC, 8'hAA, SIZE_W'(UNITS));
    send_request(KIND_ALLOC, 8'h03, 11'd1);
    send_request(KIND_RELEASE, 8'hAA, '0);
    send_request(KIND_ALLOC, 8'h55, SIZE_W'(UNITS));
    send_request(KIND_RELEASE, 8'h55, '0);
    // Two halves: one unit too many fails, the exact half fits.
    send_request(KIND_ALLOC, 8'h01, SIZE_W'(UNITS / 2));
    send_request(KIND_ALLOC, 8'h02, SIZE_W'(UNITS / 2 + 1));
    send_request(KIND_ALLOC, 8'h02, SIZE_W'(UNITS / 2));
    send_request(KIND_RELEASE, 8'h01, '0);
    send_request(KIND_RELEASE, 8'h02, '0);

    // Mostly small allocations and releases of ids that are likely to own units.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 32 == 0) begin
        gaps_off = ($urandom_range(0, 3) == 0);
      end
      pick = $urandom_range(0, 99);
      id   = ($urandom_range(0, 9) < 7) ? id_pool[$urandom_range(0, POOL_IDS - 1)]
                                        : ID_W'($urandom_range(0, 255));
      if (pick < 60) begin
        sel = $urandom_range(0, 99);
        if (sel < 70) begin
          sz = SIZE_W'($urandom_range(1, 32));
        end else if (sel < 85) begin
          sz = SIZE_W'($urandom_range(33, 256));
        end else if (sel < 92) begin
          sz = SIZE_W'($urandom_range(257, UNITS));
        end else if (sel < 95) begin
          sz = SIZE_W'(UNITS);
        end else if (sel < 97) begin
          sz = '0;
        end else begin
          sz = SIZE_W'($urandom_range(UNITS + 1, 2047));
        end
        send_request(KIND_ALLOC, id, sz);
      end else begin
        send_request(KIND_RELEASE, id, SIZE_W'($urandom_range(0, 2047)));
      end
    end
    req_ch.valid <= 1'b0;

    // Drain: let the checker see the last request, then all results.
    @(posedge clk);
    wait (outstanding == 0);
    repeat (2 * UNITS + 8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Result side: sometimes always ready, sometimes a stall before the item
  // shows up, sometimes a stall while the item is already waiting.
  initial begin
    int stall;
    rsp_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = $urandom_range(0, 12);
      if (gaps_off || stall == 0) begin
        rsp_ch.ready <= 1'b1;
      end else if ($urandom_range(0, 1) == 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
        rsp_ch.ready <= 1'b1;
      end else begin
        rsp_ch.ready <= 1'b0;
        @(posedge clk);
        while (!rsp_ch.valid) @(posedge clk);
        repeat (stall) @(posedge clk);
        rsp_ch.ready <= 1'b1;
      end
      @(posedge clk);
      while (!rsp_ch.valid) @(posedge clk);
    end
  end

  // Hang guard, several times the slowest legal run.
  initial begin
    #40_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
`default_nettype wire

[sim.f]
design/ffua_pkg.sv
design/ffua_if.sv
design/ffua_table.sv
design/ffua_seq.sv
design/first_fit_unit_allocator_top.sv
tb/ffua_checker.sv
tb/tb.sv
